@@ rtl/pcm_vol_pkg.sv @@
// Shared types and constants for the PCM byte stream volume scaler.
package pcm_vol_pkg;

   localparam int GAIN_W   = 15;
   localparam int SW_W     = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = GAIN_W;
   localparam int Q_SHIFT  = 14;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 15'd16384;
   localparam logic [GAIN_W-1:0] MUTE_GAIN  = 15'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN         = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_WIDTH = 1'd1;

   // sample width codes
   localparam logic [SW_W-1:0] SW_8  = 2'd0;
   localparam logic [SW_W-1:0] SW_16 = 2'd1;
   localparam logic [SW_W-1:0] SW_24 = 2'd2;
   localparam logic [SW_W-1:0] SW_32 = 2'd3;

   // 24-bit saturation bounds on the shifted product
   localparam logic signed [33:0] SAT_HI = 34'sh0007FFFFF;
   localparam logic signed [33:0] SAT_LO = -34'sh000800000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       buffer_done;
   } rsp_type;

endpackage

@@ rtl/pcm_byte_stream_volume_scaler.sv @@
// Top level: byte assembly, Q14 gain multiply and byte-serial result drain.
//
//  channel  ports                          direction  payload
//  req      req_valid/req_ready/req_data   in         data_byte, buffer_end
//  rsp      rsp_valid/rsp_ready/rsp_data   out        out_byte, run_last, buffer_done
//  csr      csr_we/csr_index/csr_wdata     in         gain, sample_width
//
// One byte is accepted per cycle while req_ready is high. A byte that completes a
// sample or ends a buffer goes to a sample register; the multiply sits between it
// and the drain buffer, which sends one byte per cycle while rsp_ready is high, so the
// sustained rate is one byte per cycle; results are offered from the drain buffer.
// Reset clears held bytes, both pipeline stages and sets gain to unity, 16 bit.
// rsp stalls back up through the drain buffer and the sample register into req.
module pcm_byte_stream_volume_scaler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pcm_vol_pkg::req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pcm_vol_pkg::rsp_type                  rsp_data,
   input  logic                                  csr_we,
   input  logic [pcm_vol_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcm_vol_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration
   logic [pcm_vol_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [pcm_vol_pkg::SW_W-1:0]   sw_ff, sw_in;

   // partial sample
   logic [23:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;

   // sample register
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_word_ff, s1_word_in;
   logic [2:0]  s1_count_ff, s1_count_in;
   logic        s1_full_ff, s1_full_in;
   logic        s1_last_ff, s1_last_in;

   // drain buffer
   logic [31:0] buf_word_ff, buf_word_in;
   logic [2:0]  buf_count_ff, buf_count_in;
   logic        buf_last_ff, buf_last_in;

   logic        req_fire, rsp_fire, s1_move;
   logic [2:0]  nbytes, count;
   logic [31:0] word;
   logic        emit;

   logic signed [31:0] samp;
   logic signed [15:0] gain_s;
   logic signed [47:0] prod;
   logic signed [33:0] shifted;
   logic [31:0]        scaled, out_word;

   assign rsp_valid = (buf_count_ff != 3'd0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign s1_move   = s1_valid_ff &&
                      ((buf_count_ff == 3'd0) || ((buf_count_ff == 3'd1) && rsp_ready));
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire  = req_valid && req_ready;

   assign rsp_data.out_byte    = buf_word_ff[7:0];
   assign rsp_data.run_last    = (buf_count_ff == 3'd1);
   assign rsp_data.buffer_done = (buf_count_ff == 3'd1) && buf_last_ff;

   // byte assembly
   always_comb begin
      nbytes = {1'b0, sw_ff} + 3'd1;
      count  = {1'b0, held_count_ff} + 3'd1;
      word   = {8'd0, held_bytes_ff} |
               ({24'd0, req_data.data_byte} << {held_count_ff, 3'b000});
      emit   = (count == nbytes) || req_data.buffer_end;
   end

   // gain multiply, floor shift, 24-bit saturation, mute and unity/partial bypass
   always_comb begin
      unique case (sw_ff)
         pcm_vol_pkg::SW_8:  samp = {{24{s1_word_ff[7]}}, s1_word_ff[7:0]};
         pcm_vol_pkg::SW_16: samp = {{16{s1_word_ff[15]}}, s1_word_ff[15:0]};
         pcm_vol_pkg::SW_24: samp = {{8{s1_word_ff[23]}}, s1_word_ff[23:0]};
         pcm_vol_pkg::SW_32: samp = s1_word_ff;
         default:            samp = s1_word_ff;
      endcase
      gain_s  = {1'b0, gain_ff};
      prod    = 48'(samp) * 48'(gain_s);
      // dropping the low bits of a two's complement value floors
      shifted = prod[47:pcm_vol_pkg::Q_SHIFT];
      scaled  = shifted[31:0];
      if (sw_ff == pcm_vol_pkg::SW_24) begin
         if (shifted > pcm_vol_pkg::SAT_HI) begin
            scaled = {8'd0, pcm_vol_pkg::SAT_HI[23:0]};
         end else if (shifted < pcm_vol_pkg::SAT_LO) begin
            scaled = {8'd0, pcm_vol_pkg::SAT_LO[23:0]};
         end
      end
      if (gain_ff == pcm_vol_pkg::MUTE_GAIN) begin
         out_word = 32'd0;
      end else if (!s1_full_ff || (gain_ff == pcm_vol_pkg::UNITY_GAIN)) begin
         out_word = s1_word_ff;
      end else begin
         out_word = scaled;
      end
   end

   always_comb begin
      gain_in       = gain_ff;
      sw_in         = sw_ff;
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      s1_valid_in   = s1_valid_ff;
      s1_word_in    = s1_word_ff;
      s1_count_in   = s1_count_ff;
      s1_full_in    = s1_full_ff;
      s1_last_in    = s1_last_ff;
      buf_word_in   = buf_word_ff;
      buf_count_in  = buf_count_ff;
      buf_last_in   = buf_last_ff;

      if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      if (req_fire) begin
         if (emit) begin
            held_bytes_in = 24'd0;
            held_count_in = 2'd0;
            s1_valid_in   = 1'b1;
            s1_word_in    = word;
            s1_count_in   = count;
            s1_full_in    = (count == nbytes);
            s1_last_in    = req_data.buffer_end;
         end else begin
            held_bytes_in = word[23:0];
            held_count_in = count[1:0];
         end
      end

      if (s1_move) begin
         buf_word_in  = out_word;
         buf_count_in = s1_count_ff;
         buf_last_in  = s1_last_ff;
      end else if (rsp_fire) begin
         buf_word_in  = {8'd0, buf_word_ff[31:8]};
         buf_count_in = buf_count_ff - 3'd1;
      end

      if (csr_we) begin
         unique case (csr_index)
            pcm_vol_pkg::CSR_GAIN: begin
               gain_in = csr_wdata;
            end
            pcm_vol_pkg::CSR_SAMPLE_WIDTH: begin
               sw_in         = csr_wdata[pcm_vol_pkg::SW_W-1:0];
               held_bytes_in = 24'd0;
               held_count_in = 2'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= pcm_vol_pkg::UNITY_GAIN;
         sw_ff         <= pcm_vol_pkg::SW_16;
         held_bytes_ff <= 24'd0;
         held_count_ff <= 2'd0;
         s1_valid_ff   <= 1'b0;
         buf_count_ff  <= 3'd0;
      end else begin
         gain_ff       <= gain_in;
         sw_ff         <= sw_in;
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
         s1_valid_ff   <= s1_valid_in;
         buf_count_ff  <= buf_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      s1_count_ff <= s1_count_in;
      s1_full_ff  <= s1_full_in;
      s1_last_ff  <= s1_last_in;
      buf_word_ff <= buf_word_in;
      buf_last_ff <= buf_last_in;
   end

`ifndef SYNTHESIS
   // a partial sample never reaches the configured sample size
   a_held_below_width: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= sw_ff)
      else $error("held byte count reached sample size");

   // handoff loads exactly the stored byte count into the drain buffer
   a_handoff_count: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (buf_count_ff == $past(s1_count_ff)))
      else $error("drain buffer count differs from sample register");

   // drain buffer holds one to four bytes or is empty
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      buf_count_ff <= 3'd4)
      else $error("drain buffer count out of range");

   // a buffer can only close on the last byte of a transaction
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.buffer_done) |-> rsp_data.run_last)
      else $error("buffer_done without run_last");
`endif

endmodule
